### rtl/minmax_envelope_decimator_defines.svh
// ----------------------------------------------------------------------------
// Min/max envelope decimator: assertion macros
// Concurrent assertion helpers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MINMAX_ENVELOPE_DECIMATOR_DEFINES_SVH
`define MINMAX_ENVELOPE_DECIMATOR_DEFINES_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define MMED_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
// condition must never be true outside reset
`define MMED_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `MMED_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define MMED_ASSERT(lbl, clk, rst_n, prop)
`define MMED_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### rtl/mmed_pkg.sv
// ----------------------------------------------------------------------------
// Min/max envelope decimator package
// Shared widths, register indexes and the divider status type.
// ----------------------------------------------------------------------------
package mmed_pkg;

  localparam int unsigned SampleBits  = 16;
  localparam int unsigned MaxColumns  = 4096;
  localparam int unsigned TotalBits   = 32;
  localparam int unsigned ColBits     = 13;
  localparam int unsigned ColIdxBits  = 12;
  localparam int unsigned CfgIdxBits  = 1;
  localparam int unsigned CfgDataBits = 32;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_TOTAL = 1'b0,
    CFG_COLS  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### rtl/mmed_intf.sv
// ----------------------------------------------------------------------------
// Min/max envelope decimator channels
// Valid/ready channels for the sample stream and the column result stream.
// ----------------------------------------------------------------------------
interface mmed_smp_if #(
  parameter int unsigned SAMPLE_BITS = mmed_pkg::SampleBits
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mmed_col_if #(
  parameter int unsigned SAMPLE_BITS = mmed_pkg::SampleBits
);
  logic                              valid;
  logic                              ready;
  logic [mmed_pkg::ColIdxBits-1:0]   column_index;
  logic signed [SAMPLE_BITS-1:0]     column_min;
  logic signed [SAMPLE_BITS-1:0]     column_max;
  logic                              last_column;
  logic                              mode_error;

  modport source (
    output valid, output column_index, output column_min, output column_max,
    output last_column, output mode_error, input ready
  );
  modport sink (
    input valid, input column_index, input column_min, input column_max,
    input last_column, input mode_error, output ready
  );
endinterface

### rtl/minmax_envelope_decimator.sv
// ----------------------------------------------------------------------------
// Min/max envelope decimator
// Splits a range of samples into display columns and emits each column's
// minimum and maximum.
// ----------------------------------------------------------------------------
// Usage:
//   smp_i carries one signed sample per word; col_o carries one word per
//   completed column (index, min, max, last flag) or, when the range has no
//   more than eight samples per column, one mode-error word per sample.
//   Registers total_samples (index CFG_TOTAL) and column_count (CFG_COLS)
//   are written through cfg_we_i/cfg_idx_i/cfg_data_i while the block idles;
//   each write restarts the range.
//   Throughput: one sample per cycle while not held (see below). A result
//   word appears on col_o the cycle after the sample that closes the column
//   is taken. After a register write smp_i.ready stays low while the serial
//   divider forms total/columns, one quotient bit per cycle.
//   Reset gives total = 1, columns = 1 and an empty output register.
//   When col_o is stalled the pending word holds and smp_i.ready stays low
//   until that word has been taken.
// ----------------------------------------------------------------------------
`include "minmax_envelope_decimator_defines.svh"

module minmax_envelope_decimator #(
  parameter int unsigned MAX_COLUMNS = mmed_pkg::MaxColumns,
  parameter int unsigned SAMPLE_BITS = mmed_pkg::SampleBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mmed_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [mmed_pkg::CfgDataBits-1:0]  cfg_data_i,
  mmed_smp_if.sink                          smp_i,
  mmed_col_if.source                        col_o
);

  localparam int unsigned TB = mmed_pkg::TotalBits;
  localparam int unsigned CB = mmed_pkg::ColBits;
  localparam logic signed [SAMPLE_BITS-1:0] PosOne = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] NegOne = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // configuration
  logic [TB-1:0] tot_q;
  logic [CB-1:0] cols_q;
  logic          div_start_q;
  logic [CB-1:0] w_eff;
  logic [CB+2:0] w_x8;
  logic          mode_err;

  // column tracking
  logic [TB-1:0] q_q, bnd_q, cnt_q, cnt_inc, bnd_add;
  logic [CB-1:0] r_q, rem_q, col_q;
  logic signed [SAMPLE_BITS-1:0] min_q, max_q, min_new, max_new;
  logic [CB:0]   rem_sum;
  logic          wrap, hit, last;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [mmed_pkg::ColIdxBits-1:0] out_idx_q;
  logic signed [SAMPLE_BITS-1:0]  out_min_q, out_max_q;
  logic                           out_last_q, out_err_q;

  logic [TB-1:0]         div_quo;
  logic [CB-1:0]         div_rem;
  mmed_pkg::div_status_t div_st;
  logic                  hold, accept;

  always_comb begin
    if (cols_q == '0) begin
      w_eff = CB'(1);
    end else if (32'(cols_q) > 32'(MAX_COLUMNS)) begin
      w_eff = CB'(MAX_COLUMNS);
    end else begin
      w_eff = cols_q;
    end
  end

  assign w_x8     = {w_eff, 3'b000};
  assign mode_err = tot_q <= TB'(w_x8);

  mmed_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (tot_q),
    .divisor_i  (w_eff),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .status_o   (div_st)
  );

  assign hold        = div_start_q | div_st.busy | div_st.done;
  assign smp_i.ready = !hold && (!out_valid_q || col_o.ready);
  assign accept      = smp_i.valid && smp_i.ready;

  assign min_new = (smp_i.sample < min_q) ? smp_i.sample : min_q;
  assign max_new = (smp_i.sample > max_q) ? smp_i.sample : max_q;
  assign cnt_inc = cnt_q + TB'(1);
  assign hit     = !(cnt_inc < bnd_q);
  assign last    = ({1'b0, col_q} + (CB+1)'(1)) >= {1'b0, w_eff};

  // next column end: quotient step plus carry out of the remainder sum
  assign rem_sum = {1'b0, rem_q} + {1'b0, r_q};
  assign wrap    = rem_sum >= {1'b0, w_eff};
  assign bnd_add = bnd_q + q_q + TB'(wrap);

  assign out_valid_d = accept ? (mode_err || hit) : (out_valid_q && !col_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q       <= TB'(1);
      cols_q      <= CB'(1);
      div_start_q <= 1'b0;
      q_q         <= TB'(1);
      r_q         <= '0;
      bnd_q       <= TB'(1);
      rem_q       <= '0;
      cnt_q       <= '0;
      col_q       <= '0;
      min_q       <= PosOne;
      max_q       <= NegOne;
      out_valid_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mmed_pkg::CFG_TOTAL: begin
            tot_q       <= cfg_data_i[TB-1:0];
            div_start_q <= 1'b1;
          end
          mmed_pkg::CFG_COLS: begin
            cols_q      <= cfg_data_i[CB-1:0];
            div_start_q <= 1'b1;
          end
          default: ;
        endcase
        cnt_q <= '0;
        col_q <= '0;
        min_q <= PosOne;
        max_q <= NegOne;
      end else if (div_st.done) begin
        q_q   <= div_quo;
        r_q   <= div_rem;
        bnd_q <= div_quo;
        rem_q <= div_rem;
      end else if (accept && !mode_err) begin
        if (hit && last) begin
          cnt_q <= '0;
          col_q <= '0;
          bnd_q <= q_q;
          rem_q <= r_q;
          min_q <= PosOne;
          max_q <= NegOne;
        end else if (hit) begin
          cnt_q <= cnt_inc;
          col_q <= col_q + CB'(1);
          bnd_q <= bnd_add;
          rem_q <= wrap ? CB'(rem_sum - {1'b0, w_eff}) : rem_sum[CB-1:0];
          min_q <= PosOne;
          max_q <= NegOne;
        end else begin
          cnt_q <= cnt_inc;
          min_q <= min_new;
          max_q <= max_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (mode_err) begin
        out_idx_q  <= '0;
        out_min_q  <= '0;
        out_max_q  <= '0;
        out_last_q <= 1'b0;
        out_err_q  <= 1'b1;
      end else if (hit) begin
        out_idx_q  <= col_q[mmed_pkg::ColIdxBits-1:0];
        out_min_q  <= min_new;
        out_max_q  <= max_new;
        out_last_q <= last;
        out_err_q  <= 1'b0;
      end
    end
  end

  assign col_o.valid        = out_valid_q;
  assign col_o.column_index = out_idx_q;
  assign col_o.column_min   = out_min_q;
  assign col_o.column_max   = out_max_q;
  assign col_o.last_column  = out_last_q;
  assign col_o.mode_error   = out_err_q;

  `MMED_ASSERT(a_minmax_order, clk_i, rst_ni,
    (col_o.valid && !col_o.mode_error) |-> (col_o.column_min <= col_o.column_max))
  `MMED_ASSERT(a_err_fields_zero, clk_i, rst_ni,
    (col_o.valid && col_o.mode_error) |-> (col_o.column_index == '0 && !col_o.last_column))
  `MMED_ASSERT(a_rem_in_range, clk_i, rst_ni, !hold |-> (rem_q < w_eff))
  `MMED_ASSERT(a_cnt_below_bnd, clk_i, rst_ni, (!hold && !mode_err) |-> (cnt_q < bnd_q))

endmodule

### rtl/mmed_div.sv
// ----------------------------------------------------------------------------
// Min/max envelope decimator: column width divider
// Restoring divider, one quotient bit per cycle, total / columns.
// ----------------------------------------------------------------------------
module mmed_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mmed_pkg::TotalBits-1:0]  dividend_i,
  input  logic [mmed_pkg::ColBits-1:0]    divisor_i,
  output logic [mmed_pkg::TotalBits-1:0]  quo_o,
  output logic [mmed_pkg::ColBits-1:0]    rem_o,
  output mmed_pkg::div_status_t           status_o
);

  localparam int unsigned CntBits = $clog2(mmed_pkg::TotalBits + 1);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [CntBits-1:0]             cnt_q, cnt_d;
  logic [mmed_pkg::TotalBits-1:0] quo_q, quo_d;
  logic [mmed_pkg::ColBits-1:0]   rem_q, rem_d;
  logic [mmed_pkg::ColBits:0]     rem_sh;
  logic [mmed_pkg::ColBits:0]     rem_sub;
  logic                           ge;

  assign rem_sh  = {rem_q, quo_q[mmed_pkg::TotalBits-1]};
  assign ge      = rem_sh >= {1'b0, divisor_i};
  assign rem_sub = rem_sh - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(mmed_pkg::TotalBits);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[mmed_pkg::TotalBits-2:0], ge};
      rem_d = ge ? rem_sub[mmed_pkg::ColBits-1:0] : rem_sh[mmed_pkg::ColBits-1:0];
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quo_o           = quo_q;
  assign rem_o           = rem_q;
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule
